// File: src/assert_macros.svh
// concurrent assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the cycle after
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/hltf_pkg.sv
// shared widths, register indexes and reset values of the framer
package hltf_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned PosW   = 17;
  localparam int unsigned LenW   = 16;
  localparam int unsigned CfgIdxW = 2;

  // register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] RegHeadFirst   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegHeadSecond  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegHeadConfirm = 2'd2;
  localparam logic [CfgIdxW-1:0] RegTailByte    = 2'd3;

  // register reset values
  localparam logic [ByteW-1:0] HeadFirstRst   = 8'h53;
  localparam logic [ByteW-1:0] HeadSecondRst  = 8'h54;
  localparam logic [ByteW-1:0] HeadConfirmRst = 8'hFF;
  localparam logic [ByteW-1:0] TailByteRst    = 8'h45;

  // frame positions
  localparam logic [PosW-1:0] PosHead0  = 17'd0;
  localparam logic [PosW-1:0] PosHead1  = 17'd1;
  localparam logic [PosW-1:0] PosHead2  = 17'd2;
  localparam logic [PosW-1:0] PosLenHi  = 17'd3;
  localparam logic [PosW-1:0] PosLenLo  = 17'd4;
  localparam logic [PosW-1:0] PosPayload = 17'd5;

  // one result item
  typedef struct packed {
    logic              store_en;
    logic [PosW-1:0]   store_index;
    logic [ByteW-1:0]  store_data;
    logic              frame_done;
  } result_t;

endpackage

// File: src/hltf_if.sv
// valid/ready channel interfaces of the framer
interface hltf_in_if;
  logic                         valid;
  logic                         ready;
  logic [hltf_pkg::ByteW-1:0]   rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface hltf_out_if;
  logic                         valid;
  logic                         ready;
  logic                         store_en;
  logic [hltf_pkg::PosW-1:0]    store_index;
  logic [hltf_pkg::ByteW-1:0]   store_data;
  logic                         frame_done;

  modport source (output valid, output store_en, output store_index,
                  output store_data, output frame_done, input ready);
  modport sink   (input valid, input store_en, input store_index,
                  input store_data, input frame_done, output ready);
endinterface

interface hltf_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [hltf_pkg::CfgIdxW-1:0]  index;
  logic [hltf_pkg::ByteW-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: src/header_length_tail_framer_top.sv
// top level of the header, length, payload and tail framer
//
//  channel | dir | payload                                          | request moves
//  rx_i    | in  | rx_byte                                          | one received byte
//  st_o    | out | store_en, store_index, store_data, frame_done    | one buffer write report
//  cfg_i   | in  | index, data                                      | one register write
//
// every received byte is handled combinationally: header compare, length capture and the
// tail compare sit between the frame state and a single result register
// a new request is taken each cycle while the result register is empty or drained
// reset returns to the first header search and loads the default match bytes
// a stalled result holds st_o and stops rx_i; cfg_i is always ready
`include "assert_macros.svh"

module header_length_tail_framer_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  hltf_in_if.sink       rx_i,
  hltf_out_if.source    st_o,
  hltf_cfg_if.sink      cfg_i
);

  // match registers
  logic [hltf_pkg::ByteW-1:0] head_first_q, head_second_q, head_confirm_q, tail_byte_q;

  // frame state
  logic [hltf_pkg::PosW-1:0] pos_q, pos_d;
  logic [hltf_pkg::LenW-1:0] len_q, len_d;
  logic [hltf_pkg::PosW-1:0] tail_pos;

  // result register
  logic              out_valid_q;
  hltf_pkg::result_t res_q, res_d;

  logic rx_acc;
  logic [hltf_pkg::ByteW-1:0] b;

  // terms for the checks
  logic res_vld_done;
  logic res_vld_skip;
  logic res_fields_zero;

  assign b           = rx_i.rx_byte;
  assign rx_i.ready  = !out_valid_q || st_o.ready;
  assign rx_acc      = rx_i.valid && rx_i.ready;
  assign cfg_i.ready = 1'b1;

  // tail sits right after the payload
  assign tail_pos = hltf_pkg::PosW'(len_q) + hltf_pkg::PosPayload;

  // next frame state and result for the byte at the input
  always_comb begin
    pos_d = pos_q;
    len_d = len_q;
    res_d = '0;
    case (pos_q)
      hltf_pkg::PosHead0: begin
        if (b == head_first_q) begin
          res_d.store_en = 1'b1;
          pos_d          = hltf_pkg::PosHead1;
        end
      end
      hltf_pkg::PosHead1: begin
        if (b == head_second_q) begin
          res_d.store_en = 1'b1;
          pos_d          = hltf_pkg::PosHead2;
        end
      end
      hltf_pkg::PosHead2: begin
        if (b == head_confirm_q) begin
          res_d.store_en = 1'b1;
          pos_d          = hltf_pkg::PosLenHi;
        end
      end
      hltf_pkg::PosLenHi: begin
        len_d          = {b, len_q[hltf_pkg::ByteW-1:0]};
        res_d.store_en = 1'b1;
        pos_d          = hltf_pkg::PosLenLo;
      end
      hltf_pkg::PosLenLo: begin
        len_d          = {len_q[hltf_pkg::LenW-1:hltf_pkg::ByteW], b};
        res_d.store_en = 1'b1;
        pos_d          = hltf_pkg::PosPayload;
      end
      default: begin
        if (pos_q < tail_pos) begin
          // payload byte
          res_d.store_en = 1'b1;
          pos_d          = pos_q + hltf_pkg::PosW'(1);
        end else begin
          // tail: a good one closes the frame, a bad one drops it
          if (b == tail_byte_q) begin
            res_d.store_en   = 1'b1;
            res_d.frame_done = 1'b1;
          end
          pos_d = hltf_pkg::PosHead0;
        end
      end
    endcase
    if (res_d.store_en) begin
      res_d.store_index = pos_q;
      res_d.store_data  = b;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_first_q   <= hltf_pkg::HeadFirstRst;
      head_second_q  <= hltf_pkg::HeadSecondRst;
      head_confirm_q <= hltf_pkg::HeadConfirmRst;
      tail_byte_q    <= hltf_pkg::TailByteRst;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.index)
        hltf_pkg::RegHeadFirst:   head_first_q   <= cfg_i.data;
        hltf_pkg::RegHeadSecond:  head_second_q  <= cfg_i.data;
        hltf_pkg::RegHeadConfirm: head_confirm_q <= cfg_i.data;
        hltf_pkg::RegTailByte:    tail_byte_q    <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // frame state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= hltf_pkg::PosHead0;
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (rx_acc) begin
        pos_q       <= pos_d;
        len_q       <= len_d;
        out_valid_q <= 1'b1;
      end else if (st_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (rx_acc) begin
      res_q <= res_d;
    end
  end

  assign st_o.valid       = out_valid_q;
  assign st_o.store_en    = res_q.store_en;
  assign st_o.store_index = res_q.store_index;
  assign st_o.store_data  = res_q.store_data;
  assign st_o.frame_done  = res_q.frame_done;

  // checks
  assign res_vld_done    = out_valid_q && res_q.frame_done;
  assign res_vld_skip    = out_valid_q && !res_q.store_en;
  assign res_fields_zero = (res_q.store_index == '0) && (res_q.store_data == '0);

  `ASSERT_ALWAYS(a_pos_in_frame, clk_i, rst_ni, pos_q <= tail_pos, "position past tail")
  `ASSERT_IMPLY(a_done_stores, clk_i, rst_ni, res_vld_done, res_q.store_en, "done without store")
  `ASSERT_IMPLY(a_idle_zero, clk_i, rst_ni, res_vld_skip, res_fields_zero, "fields without store")
  `ASSERT_NEXT(a_accept_result, clk_i, rst_ni, rx_acc, out_valid_q, "no result after accept")

endmodule

// File: tb/tb_top.sv
// self-checking bench for the header, length, payload and tail framer
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // how the two sides of the block idle during a phase
  typedef enum int {
    IdleNone,
    IdleSender,
    IdleReceiver,
    IdleBoth
  } idle_mode_e;

  logic clk_i;
  logic rst_ni;

  hltf_in_if  rx_if ();
  hltf_out_if st_if ();
  hltf_cfg_if cfg_if ();

  header_length_tail_framer_top uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if),
    .st_o   (st_if),
    .cfg_i  (cfg_if)
  );

  // bytes still to be offered on the receive side, and the buffer write
  // reports that the block owes us, oldest first
  logic [hltf_pkg::ByteW-1:0] rx_bytes_pending [$];
  hltf_pkg::result_t          store_reports_due [$];

  int unsigned bytes_queued;
  int unsigned bytes_accepted;
  int unsigned mismatch_count;
  idle_mode_e  idle_mode;

  // our own copy of the match registers and of the frame state
  logic [hltf_pkg::ByteW-1:0] match_first;
  logic [hltf_pkg::ByteW-1:0] match_second;
  logic [hltf_pkg::ByteW-1:0] match_confirm;
  logic [hltf_pkg::ByteW-1:0] match_tail;
  logic [hltf_pkg::PosW-1:0]  frame_pos;
  logic [hltf_pkg::LenW-1:0]  frame_len;

  // free-running clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // watchdog: far beyond the slowest correct run
  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end

  // expected buffer write for one received byte, advancing the frame state
  function automatic hltf_pkg::result_t predict_store_report(
      logic [hltf_pkg::ByteW-1:0] rx_byte);
    hltf_pkg::result_t         rep;
    logic [hltf_pkg::PosW-1:0] idx;
    logic [hltf_pkg::PosW-1:0] tail_pos;
    rep      = '0;
    idx      = frame_pos;
    tail_pos = {1'b0, frame_len} + hltf_pkg::PosPayload;
    if (idx == hltf_pkg::PosHead0) begin
      // header bytes that do not match are dropped without restarting
      if (rx_byte == match_first) begin
        rep.store_en = 1'b1;
        frame_pos    = hltf_pkg::PosHead1;
      end
    end else if (idx == hltf_pkg::PosHead1) begin
      if (rx_byte == match_second) begin
        rep.store_en = 1'b1;
        frame_pos    = hltf_pkg::PosHead2;
      end
    end else if (idx == hltf_pkg::PosHead2) begin
      if (rx_byte == match_confirm) begin
        rep.store_en = 1'b1;
        frame_pos    = hltf_pkg::PosLenHi;
      end
    end else if (idx == hltf_pkg::PosLenHi) begin
      frame_len[15:8] = rx_byte;
      rep.store_en    = 1'b1;
      frame_pos       = hltf_pkg::PosLenLo;
    end else if (idx == hltf_pkg::PosLenLo) begin
      frame_len[7:0] = rx_byte;
      rep.store_en   = 1'b1;
      frame_pos      = hltf_pkg::PosPayload;
    end else if (idx < tail_pos) begin
      rep.store_en = 1'b1;
      frame_pos    = idx + hltf_pkg::PosW'(1);
    end else begin
      // tail slot: a wrong tail drops the frame and is not a header candidate
      if (rx_byte == match_tail) begin
        rep.store_en   = 1'b1;
        rep.frame_done = 1'b1;
      end
      frame_pos = hltf_pkg::PosHead0;
    end
    if (rep.store_en) begin
      rep.store_index = idx;
      rep.store_data  = rx_byte;
    end
    return rep;
  endfunction

  function automatic bit sender_gap();
    case (idle_mode)
      IdleSender: return $urandom_range(99) < 46;
      IdleBoth:   return $urandom_range(99) < 10;
      default:    return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stall();
    case (idle_mode)
      IdleReceiver: return $urandom_range(99) < 46;
      IdleBoth:     return $urandom_range(99) < 10;
      default:      return 1'b0;
    endcase
  endfunction

  // receive-side driver: an accepted request is predicted at the edge that
  // takes it, then the next byte (or a gap) is put on the channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rx_if.valid && rx_if.ready) begin
        store_reports_due.push_back(predict_store_report(rx_if.rx_byte));
        bytes_accepted++;
      end
      // a request not yet taken stays on the channel untouched
      if (!(rx_if.valid && !rx_if.ready)) begin
        if (rx_bytes_pending.size() > 0 && !sender_gap()) begin
          rx_if.valid   <= 1'b1;
          rx_if.rx_byte <= rx_bytes_pending.pop_front();
        end else begin
          rx_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor: every report taken is checked against the oldest one due
  always @(posedge clk_i) begin
    hltf_pkg::result_t got;
    hltf_pkg::result_t want;
    if (rst_ni) begin
      if (st_if.valid && st_if.ready) begin
        got.store_en    = st_if.store_en;
        got.store_index = st_if.store_index;
        got.store_data  = st_if.store_data;
        got.frame_done  = st_if.frame_done;
        if (store_reports_due.size() == 0) begin
          $display("%0t: unexpected report en=%0d idx=%0d data=%h done=%0d", $realtime,
                   got.store_en, got.store_index, got.store_data, got.frame_done);
          mismatch_count++;
        end else begin
          want = store_reports_due.pop_front();
          if (got !== want) begin
            $display("%0t: report mismatch: expected en=%0d idx=%0d data=%h done=%0d",
                     $realtime, want.store_en, want.store_index, want.store_data,
                     want.frame_done);
            $display("%0t:                   actual en=%0d idx=%0d data=%h done=%0d",
                     $realtime, got.store_en, got.store_index, got.store_data,
                     got.frame_done);
            mismatch_count++;
          end
        end
      end
      st_if.ready <= !receiver_stall();
    end
  end

  task automatic queue_byte(logic [hltf_pkg::ByteW-1:0] b);
    rx_bytes_pending.push_back(b);
    bytes_queued++;
  endtask

  // a full frame with random payload; a bad tail differs from the match value
  task automatic queue_frame(logic [hltf_pkg::LenW-1:0] len, bit tail_ok);
    int unsigned k;
    queue_byte(match_first);
    queue_byte(match_second);
    queue_byte(match_confirm);
    queue_byte(len[15:8]);
    queue_byte(len[7:0]);
    for (k = 0; k < len; k++) queue_byte(8'($urandom));
    if (tail_ok) queue_byte(match_tail);
    else queue_byte(match_tail ^ 8'($urandom_range(1, 255)));
  endtask

  // mostly well-formed frames, with bad tails, cut headers and line noise mixed in
  task automatic queue_random_traffic(int unsigned n_items);
    int unsigned frame_bytes;
    int unsigned start;
    int unsigned pick;
    int unsigned k;
    frame_bytes = 0;
    while (frame_bytes < n_items) begin
      start = bytes_queued;
      pick  = $urandom_range(99);
      if (pick < 70) begin
        if ($urandom_range(19) == 0) queue_frame(16'($urandom_range(13, 300)), 1'b1);
        else queue_frame(16'($urandom_range(0, 12)), 1'b1);
        frame_bytes += bytes_queued - start;
      end else if (pick < 82) begin
        queue_frame(16'($urandom_range(0, 8)), 1'b0);
        frame_bytes += bytes_queued - start;
      end else if (pick < 92) begin
        // header cut short by a stray byte at a random depth
        queue_byte(match_first);
        if ($urandom_range(1)) queue_byte(match_second);
        queue_byte(8'($urandom));
        frame_bytes += bytes_queued - start;
      end else begin
        // noise between frames; mostly dropped by the header search
        for (k = $urandom_range(1, 4); k > 0; k--) queue_byte(8'($urandom));
      end
    end
  endtask

  // block is idle once every queued byte is taken and every report has come
  task automatic wait_drained();
    do @(posedge clk_i);
    while (bytes_accepted != bytes_queued || store_reports_due.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // one register write; called at a clock edge, returns at the accepting edge
  task automatic write_reg(logic [hltf_pkg::CfgIdxW-1:0] idx,
                           logic [hltf_pkg::ByteW-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk_i);
    while (!cfg_if.ready);
    case (idx)
      hltf_pkg::RegHeadFirst:   match_first   = value;
      hltf_pkg::RegHeadSecond:  match_second  = value;
      hltf_pkg::RegHeadConfirm: match_confirm = value;
      hltf_pkg::RegTailByte:    match_tail    = value;
      default: ;
    endcase
  endtask

  // drain, load a new set of match bytes, then queue a batch of traffic
  task automatic run_phase(idle_mode_e mode, logic [hltf_pkg::ByteW-1:0] first,
                           logic [hltf_pkg::ByteW-1:0] second,
                           logic [hltf_pkg::ByteW-1:0] confirm,
                           logic [hltf_pkg::ByteW-1:0] tail, int unsigned n_items);
    wait_drained();
    write_reg(hltf_pkg::RegHeadFirst, first);
    write_reg(hltf_pkg::RegHeadSecond, second);
    write_reg(hltf_pkg::RegHeadConfirm, confirm);
    write_reg(hltf_pkg::RegTailByte, tail);
    cfg_if.valid <= 1'b0;
    idle_mode = mode;
    queue_random_traffic(n_items);
  endtask

  initial begin
    // every block input known from time zero
    rst_ni         = 1'b0;
    rx_if.valid    = 1'b0;
    rx_if.rx_byte  = '0;
    st_if.ready    = 1'b0;
    cfg_if.valid   = 1'b0;
    cfg_if.index   = hltf_pkg::RegHeadFirst;
    cfg_if.data    = '0;
    idle_mode      = IdleNone;
    bytes_queued   = 0;
    bytes_accepted = 0;
    mismatch_count = 0;
    match_first    = hltf_pkg::HeadFirstRst;
    match_second   = hltf_pkg::HeadSecondRst;
    match_confirm  = hltf_pkg::HeadConfirmRst;
    match_tail     = hltf_pkg::TailByteRst;
    frame_pos      = hltf_pkg::PosHead0;
    frame_len      = '0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: zero-length frame, so the byte after the length is the tail
    queue_frame(16'd0, 1'b1);
    // a mismatch at each header slot is ignored, then a bad tail drops the frame
    queue_byte(8'h00);
    queue_byte(hltf_pkg::HeadFirstRst);
    queue_byte(8'hFF);
    queue_byte(hltf_pkg::HeadSecondRst);
    queue_byte(8'h00);
    queue_byte(hltf_pkg::HeadConfirmRst);
    queue_byte(8'h00);
    queue_byte(8'h02);
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_byte(hltf_pkg::TailByteRst ^ 8'h01);
    // one-byte payload with a good tail right after the bad one
    queue_frame(16'd1, 1'b1);
    queue_random_traffic(150);

    // match-byte extremes, random settings and back to the reset values
    run_phase(IdleSender, 8'h00, 8'h00, 8'h00, 8'h00, 190);
    run_phase(IdleReceiver, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 190);
    run_phase(IdleBoth, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 190);
    run_phase(IdleNone, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 190);
    run_phase(IdleSender, hltf_pkg::HeadFirstRst, hltf_pkg::HeadSecondRst,
              hltf_pkg::HeadConfirmRst, hltf_pkg::TailByteRst, 190);

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+src
src/hltf_pkg.sv
src/hltf_if.sv
src/header_length_tail_framer_top.sv
tb/tb_top.sv
